[src/rrts_pkg.sv]
// shared types, constants and the control store of the task slot scheduler
package rrts_pkg;

  // table size and derived widths
  localparam int SlotCount = 8;
  localparam int SlotW     = $clog2(SlotCount);
  localparam int CntW      = $clog2(SlotCount + 1);

  // word field widths
  localparam int CmdW     = 3;
  localparam int WidW     = 8;
  localparam int TidW     = 3;
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  // control store address width
  localparam int UpcW = 5;

  typedef logic [SlotW-1:0] slot_idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [UpcW-1:0]  upc_t;

  // slot states
  typedef enum logic [2:0] {
    S_FREE    = 3'd0,
    S_READY   = 3'd1,
    S_RUNNING = 3'd2,
    S_WAITING = 3'd3,
    S_DEAD    = 3'd4
  } slot_e;

  // command codes
  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_START    = 3'd1,
    CMD_SCHEDULE = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_WAKE     = 3'd4,
    CMD_EXIT     = 3'd5,
    CMD_ACK      = 3'd6
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    RS_DONE  = 2'd0,
    RS_FULL  = 2'd1,
    RS_NOCHG = 2'd2,
    RS_HALT  = 2'd3
  } status_e;

  // table address source
  typedef enum logic [1:0] {
    A_PTR = 2'd0,
    A_CUR = 2'd1,
    A_WID = 2'd2
  } asel_e;

  // table write mode
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_SET    = 2'd1,
    WR_DEMOTE = 2'd2
  } wr_e;

  // runnable count update
  typedef enum logic [2:0] {
    CNT_HOLD     = 3'd0,
    CNT_INC      = 3'd1,
    CNT_INC_WAIT = 3'd2,
    CNT_DEC      = 3'd3,
    CNT_DEC_RUN  = 3'd4
  } cnt_e;

  // scan pointer update
  typedef enum logic [1:0] {
    PTR_HOLD      = 2'd0,
    PTR_ZERO      = 2'd1,
    PTR_AFTER_CUR = 2'd2,
    PTR_ADV       = 2'd3
  } ptr_e;

  // pending switch flag update
  typedef enum logic [1:0] {
    PEND_HOLD = 2'd0,
    PEND_SET  = 2'd1,
    PEND_CLR  = 2'd2
  } pend_e;

  // scan match predicate
  typedef enum logic [1:0] {
    M_NONE       = 2'd0,
    M_FREE       = 2'd1,
    M_READY      = 2'd2,
    M_READY_WAIT = 2'd3
  } match_e;

  // sequencer jump kinds
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_IDLE     = 3'd2,
    J_DISPATCH = 3'd3,
    J_IFNOT    = 3'd4,
    J_SCAN     = 3'd5,
    J_EMIT     = 3'd6
  } jump_e;

  // datapath tests for conditional jumps
  typedef enum logic [2:0] {
    T_SCHED = 3'd0,
    T_WAIT  = 3'd1,
    T_WAKE  = 3'd2,
    T_CUR   = 3'd3,
    T_CNT   = 3'd4,
    T_PEND  = 3'd5,
    T_START = 3'd6
  } test_e;

  // one control word
  typedef struct packed {
    asel_e   asel;
    wr_e     wr;
    slot_e   wr_val;
    cnt_e    cnt;
    ptr_e    ptr;
    logic    cur_ld;
    pend_e   pend;
    logic    halt_set;
    logic    res_clr;
    logic    st_ld;
    status_e st_val;
    logic    tid_ld;
    logic    sw_set;
    match_e  match;
    jump_e   jmp;
    test_e   test;
    upc_t    target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            halted;
    logic            test_ok;
    logic            match;
    logic            scan_last;
  } dp_stat_t;

  // result fields
  typedef struct packed {
    status_e         status;
    logic [TidW-1:0] task_id;
    logic            sw;
    logic            halted;
  } res_t;

  // control store addresses
  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_DISPATCH = 5'd1;
  localparam upc_t U_EMIT     = 5'd2;
  localparam upc_t U_HALT     = 5'd3;
  localparam upc_t U_CR0      = 5'd4;
  localparam upc_t U_CR_SCAN  = 5'd5;
  localparam upc_t U_CR_FULL  = 5'd6;
  localparam upc_t U_CR_HIT   = 5'd7;
  localparam upc_t U_CR_START = 5'd8;
  localparam upc_t U_SC0      = 5'd9;
  localparam upc_t U_SC_SCAN  = 5'd10;
  localparam upc_t U_SC_MISS  = 5'd11;
  localparam upc_t U_SC_DEM   = 5'd12;
  localparam upc_t U_SC_SW    = 5'd13;
  localparam upc_t U_WT0      = 5'd14;
  localparam upc_t U_WT1      = 5'd15;
  localparam upc_t U_WK0      = 5'd16;
  localparam upc_t U_WK1      = 5'd17;
  localparam upc_t U_EX0      = 5'd18;
  localparam upc_t U_EX1      = 5'd19;
  localparam upc_t U_EX2      = 5'd20;
  localparam upc_t U_EX_SCAN  = 5'd21;
  localparam upc_t U_EX_HALT  = 5'd22;
  localparam upc_t U_EX_HIT   = 5'd23;
  localparam upc_t U_AK0      = 5'd24;
  localparam upc_t U_AK1      = 5'd25;

  // idle control word
  localparam ctrl_t CtrlNop = '{
    asel: A_PTR, wr: WR_NONE, wr_val: S_FREE, cnt: CNT_HOLD, ptr: PTR_HOLD,
    cur_ld: 1'b0, pend: PEND_HOLD, halt_set: 1'b0, res_clr: 1'b0,
    st_ld: 1'b0, st_val: RS_DONE, tid_ld: 1'b0, sw_set: 1'b0,
    match: M_NONE, jmp: J_NEXT, test: T_CUR, target: U_IDLE
  };

  // entry point for a command word
  function automatic upc_t entry_of(logic [CmdW-1:0] cmd, logic halted);
    upc_t a;
    a = U_EMIT;
    if (halted) begin
      a = U_HALT;
    end else begin
      case (cmd)
        CMD_CREATE, CMD_START: a = U_CR0;
        CMD_SCHEDULE:          a = U_SC0;
        CMD_WAIT:              a = U_WT0;
        CMD_WAKE:              a = U_WK0;
        CMD_EXIT:              a = U_EX0;
        CMD_ACK:               a = U_AK0;
        default:               a = U_EMIT;
      endcase
    end
    return a;
  endfunction

  // microprogram
  function automatic ctrl_t ucode(upc_t a);
    ctrl_t c;
    c = CtrlNop;
    case (a)
      U_IDLE: begin
        c.jmp = J_IDLE;
      end
      U_DISPATCH: begin
        c.res_clr = 1'b1;
        c.jmp     = J_DISPATCH;
      end
      U_EMIT: begin
        c.jmp = J_EMIT;
      end
      U_HALT: begin
        c.st_ld = 1'b1; c.st_val = RS_HALT;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // create and start
      U_CR0: begin
        c.ptr = PTR_ZERO;
      end
      U_CR_SCAN: begin
        c.match = M_FREE; c.ptr = PTR_ADV;
        c.jmp = J_SCAN; c.target = U_CR_HIT;
      end
      U_CR_FULL: begin
        c.st_ld = 1'b1; c.st_val = RS_FULL;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      U_CR_HIT: begin
        c.asel = A_PTR; c.wr = WR_SET; c.wr_val = S_READY; c.cnt = CNT_INC;
        c.st_ld = 1'b1; c.st_val = RS_DONE; c.tid_ld = 1'b1;
        c.jmp = J_IFNOT; c.test = T_START; c.target = U_EMIT;
      end
      U_CR_START: begin
        c.asel = A_PTR; c.wr = WR_SET; c.wr_val = S_RUNNING;
        c.cur_ld = 1'b1; c.sw_set = 1'b1;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // schedule
      U_SC0: begin
        c.asel = A_CUR; c.ptr = PTR_AFTER_CUR;
        c.jmp = J_IFNOT; c.test = T_SCHED; c.target = U_EMIT;
      end
      U_SC_SCAN: begin
        c.match = M_READY; c.ptr = PTR_ADV;
        c.jmp = J_SCAN; c.target = U_SC_DEM;
      end
      U_SC_MISS: begin
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      U_SC_DEM: begin
        c.asel = A_CUR; c.wr = WR_DEMOTE;
      end
      U_SC_SW: begin
        c.asel = A_PTR; c.wr = WR_SET; c.wr_val = S_RUNNING;
        c.cur_ld = 1'b1; c.pend = PEND_SET;
        c.st_ld = 1'b1; c.st_val = RS_DONE; c.tid_ld = 1'b1; c.sw_set = 1'b1;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // wait
      U_WT0: begin
        c.asel = A_CUR;
        c.jmp = J_IFNOT; c.test = T_WAIT; c.target = U_EMIT;
      end
      U_WT1: begin
        c.asel = A_CUR; c.wr = WR_SET; c.wr_val = S_WAITING; c.cnt = CNT_DEC;
        c.st_ld = 1'b1; c.st_val = RS_DONE;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // wake
      U_WK0: begin
        c.asel = A_WID;
        c.jmp = J_IFNOT; c.test = T_WAKE; c.target = U_EMIT;
      end
      U_WK1: begin
        c.asel = A_WID; c.wr = WR_SET; c.wr_val = S_READY; c.cnt = CNT_INC;
        c.st_ld = 1'b1; c.st_val = RS_DONE;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // exit
      U_EX0: begin
        c.jmp = J_IFNOT; c.test = T_CUR; c.target = U_EMIT;
      end
      U_EX1: begin
        c.asel = A_CUR; c.wr = WR_SET; c.wr_val = S_DEAD; c.cnt = CNT_DEC_RUN;
        c.ptr = PTR_ZERO;
      end
      U_EX2: begin
        c.jmp = J_IFNOT; c.test = T_CNT; c.target = U_EX_HALT;
      end
      U_EX_SCAN: begin
        c.match = M_READY_WAIT; c.ptr = PTR_ADV;
        c.jmp = J_SCAN; c.target = U_EX_HIT;
      end
      U_EX_HALT: begin
        c.halt_set = 1'b1; c.st_ld = 1'b1; c.st_val = RS_HALT;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      U_EX_HIT: begin
        c.asel = A_PTR; c.wr = WR_SET; c.wr_val = S_RUNNING; c.cnt = CNT_INC_WAIT;
        c.cur_ld = 1'b1; c.pend = PEND_SET;
        c.st_ld = 1'b1; c.st_val = RS_DONE; c.tid_ld = 1'b1; c.sw_set = 1'b1;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      // switch acknowledge
      U_AK0: begin
        c.jmp = J_IFNOT; c.test = T_PEND; c.target = U_EMIT;
      end
      U_AK1: begin
        c.pend = PEND_CLR; c.st_ld = 1'b1; c.st_val = RS_DONE;
        c.jmp = J_ALWAYS; c.target = U_EMIT;
      end
      default: begin
        c.jmp = J_ALWAYS; c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[src/round_robin_task_slot_scheduler.sv]
// top level of the round-robin task slot scheduler
//
//   channel   dir  bus            fields, lowest bit up
//   command   in   s_axis_*       command[2:0], wake_id[10:3], zero[15:11]
//   result    out  m_axis_*       status[1:0], task_id[4:2], switch_request[5],
//                                 is_halted[6], zero[7]
//
// one control step per cycle; a word runs through dispatch, the steps of its command,
// including any table scan over the slots, and the emit step, and the sequencer
// returns to its idle step before the next word is taken
// reset clears the whole slot table at once, no clearing pass is needed
// a result waits in the output register while the next word is taken;
// a second result holds the sequencer at its emit step until the register frees
module round_robin_task_slot_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command, wake_id
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rrts_pkg::InDataW-1:0]  s_axis_tdata,
  // status, task_id, switch_request, is_halted
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rrts_pkg::OutDataW-1:0] m_axis_tdata
);

  rrts_pkg::ctrl_t    ctrl;
  rrts_pkg::dp_stat_t stat;
  rrts_pkg::res_t     res;

  logic in_ready;
  logic in_fire;
  logic emit;
  logic out_free;

  logic                          m_valid_q;
  logic [rrts_pkg::OutDataW-1:0] m_data_q;

  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid && in_ready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // sequencer
  rrts_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .emit_o     (emit),
    .ctrl_o     (ctrl)
  );

  // datapath
  rrts_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .cmd_i     (s_axis_tdata[rrts_pkg::CmdW-1:0]),
    .wid_i     (s_axis_tdata[rrts_pkg::CmdW +: rrts_pkg::WidW]),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .res_o     (res)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {1'b0, res.halted, res.sw, res.task_id, res.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[src/rrts_useq.sv]
// microprogram sequencer: step counter, control store and jump logic
module rrts_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  input  rrts_pkg::dp_stat_t stat_i,
  output logic               in_ready_o,
  output logic               emit_o,
  output rrts_pkg::ctrl_t    ctrl_o
);

  rrts_pkg::upc_t upc_q, upc_d;
  rrts_pkg::ctrl_t ctrl;

  // control store lookup
  assign ctrl   = rrts_pkg::ucode(upc_q);
  assign ctrl_o = ctrl;

  assign in_ready_o = (ctrl.jmp == rrts_pkg::J_IDLE);
  assign emit_o     = (ctrl.jmp == rrts_pkg::J_EMIT) && out_free_i;

  // next step selection
  always_comb begin
    upc_d = upc_q + rrts_pkg::UpcW'(1);
    case (ctrl.jmp)
      rrts_pkg::J_NEXT:     upc_d = upc_q + rrts_pkg::UpcW'(1);
      rrts_pkg::J_ALWAYS:   upc_d = ctrl.target;
      rrts_pkg::J_IDLE:     upc_d = in_valid_i ? rrts_pkg::U_DISPATCH : rrts_pkg::U_IDLE;
      rrts_pkg::J_DISPATCH: upc_d = rrts_pkg::entry_of(stat_i.cmd, stat_i.halted);
      rrts_pkg::J_IFNOT:    upc_d = stat_i.test_ok ? upc_q + rrts_pkg::UpcW'(1) : ctrl.target;
      rrts_pkg::J_SCAN: begin
        if (stat_i.match) begin
          upc_d = ctrl.target;
        end else if (stat_i.scan_last) begin
          upc_d = upc_q + rrts_pkg::UpcW'(1);
        end else begin
          upc_d = upc_q;
        end
      end
      rrts_pkg::J_EMIT:     upc_d = out_free_i ? rrts_pkg::U_IDLE : upc_q;
      default:              upc_d = rrts_pkg::U_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rrts_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[src/rrts_dpath.sv]
// datapath: slot table, current task, runnable count, flags and result fields
module rrts_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic [rrts_pkg::CmdW-1:0]   cmd_i,
  input  logic [rrts_pkg::WidW-1:0]   wid_i,
  input  rrts_pkg::ctrl_t             ctrl_i,
  output rrts_pkg::dp_stat_t          stat_o,
  output rrts_pkg::res_t              res_o
);

  rrts_pkg::slot_e slot_q [rrts_pkg::SlotCount];

  logic [rrts_pkg::CmdW-1:0] cmd_q;
  logic [rrts_pkg::WidW-1:0] wid_q;
  rrts_pkg::slot_idx_t       cur_q, cur_d;
  logic                      cur_v_q, cur_v_d;
  rrts_pkg::cnt_t            cnt_q, cnt_d;
  logic                      pend_q, pend_d;
  logic                      halt_q, halt_d;
  rrts_pkg::slot_idx_t       ptr_q, ptr_d;
  rrts_pkg::slot_idx_t       it_q, it_d;
  rrts_pkg::status_e         st_q, st_d;
  logic [rrts_pkg::TidW-1:0] tid_q, tid_d;
  logic                      sw_q, sw_d;

  rrts_pkg::slot_idx_t addr;
  rrts_pkg::slot_e     rd;
  logic                wid_ok;
  logic                match;
  logic                test_ok;
  logic                wr_en;
  rrts_pkg::slot_e     wr_data;
  rrts_pkg::slot_idx_t ptr_inc;
  rrts_pkg::slot_idx_t cur_inc;

  // wake slot range check
  assign wid_ok = {1'b0, wid_q} < (rrts_pkg::WidW + 1)'(rrts_pkg::SlotCount);

  // table address select and read
  always_comb begin
    case (ctrl_i.asel)
      rrts_pkg::A_PTR: addr = ptr_q;
      rrts_pkg::A_CUR: addr = cur_q;
      rrts_pkg::A_WID: addr = wid_ok ? wid_q[rrts_pkg::SlotW-1:0] : '0;
      default:         addr = ptr_q;
    endcase
  end
  assign rd = slot_q[addr];

  // scan predicate
  always_comb begin
    case (ctrl_i.match)
      rrts_pkg::M_FREE:       match = (rd == rrts_pkg::S_FREE);
      rrts_pkg::M_READY:      match = (rd == rrts_pkg::S_READY);
      rrts_pkg::M_READY_WAIT: match = (rd == rrts_pkg::S_READY) ||
                                      (rd == rrts_pkg::S_WAITING);
      default:                match = 1'b0;
    endcase
  end

  // jump conditions
  always_comb begin
    case (ctrl_i.test)
      rrts_pkg::T_SCHED: test_ok = cur_v_q && !pend_q &&
                                   ((rd == rrts_pkg::S_WAITING) ||
                                    (cnt_q >= rrts_pkg::CntW'(2)));
      rrts_pkg::T_WAIT:  test_ok = cur_v_q && (rd == rrts_pkg::S_RUNNING);
      rrts_pkg::T_WAKE:  test_ok = wid_ok && (rd == rrts_pkg::S_WAITING);
      rrts_pkg::T_CUR:   test_ok = cur_v_q;
      rrts_pkg::T_CNT:   test_ok = (cnt_q != '0);
      rrts_pkg::T_PEND:  test_ok = pend_q;
      rrts_pkg::T_START: test_ok = (cmd_q == rrts_pkg::CMD_START);
      default:           test_ok = 1'b0;
    endcase
  end

  assign stat_o = '{
    cmd:       cmd_q,
    halted:    halt_q,
    test_ok:   test_ok,
    match:     match,
    scan_last: (it_q == rrts_pkg::SlotW'(rrts_pkg::SlotCount - 1))
  };

  // table write
  always_comb begin
    wr_en   = 1'b0;
    wr_data = ctrl_i.wr_val;
    case (ctrl_i.wr)
      rrts_pkg::WR_SET: wr_en = 1'b1;
      rrts_pkg::WR_DEMOTE: begin
        wr_en   = (rd == rrts_pkg::S_RUNNING);
        wr_data = rrts_pkg::S_READY;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // wrap-around increments
  assign ptr_inc = (ptr_q == rrts_pkg::SlotW'(rrts_pkg::SlotCount - 1)) ?
                   '0 : ptr_q + rrts_pkg::SlotW'(1);
  assign cur_inc = (cur_q == rrts_pkg::SlotW'(rrts_pkg::SlotCount - 1)) ?
                   '0 : cur_q + rrts_pkg::SlotW'(1);

  // register updates from the control word
  always_comb begin
    cnt_d = cnt_q;
    case (ctrl_i.cnt)
      rrts_pkg::CNT_INC:      cnt_d = cnt_q + rrts_pkg::CntW'(1);
      rrts_pkg::CNT_INC_WAIT: if (rd == rrts_pkg::S_WAITING) begin
        cnt_d = cnt_q + rrts_pkg::CntW'(1);
      end
      rrts_pkg::CNT_DEC:      if (cnt_q != '0) begin
        cnt_d = cnt_q - rrts_pkg::CntW'(1);
      end
      rrts_pkg::CNT_DEC_RUN:  if (((rd == rrts_pkg::S_RUNNING) ||
                                   (rd == rrts_pkg::S_READY)) && (cnt_q != '0)) begin
        cnt_d = cnt_q - rrts_pkg::CntW'(1);
      end
      default:                cnt_d = cnt_q;
    endcase

    ptr_d = ptr_q;
    it_d  = it_q;
    case (ctrl_i.ptr)
      rrts_pkg::PTR_ZERO: begin
        ptr_d = '0;
        it_d  = '0;
      end
      rrts_pkg::PTR_AFTER_CUR: begin
        ptr_d = cur_inc;
        it_d  = '0;
      end
      rrts_pkg::PTR_ADV: if (!match) begin
        ptr_d = ptr_inc;
        it_d  = it_q + rrts_pkg::SlotW'(1);
      end
      default: ptr_d = ptr_q;
    endcase

    cur_d   = ctrl_i.cur_ld ? ptr_q : cur_q;
    cur_v_d = ctrl_i.cur_ld ? 1'b1 : cur_v_q;

    case (ctrl_i.pend)
      rrts_pkg::PEND_SET: pend_d = 1'b1;
      rrts_pkg::PEND_CLR: pend_d = 1'b0;
      default:            pend_d = pend_q;
    endcase

    halt_d = halt_q || ctrl_i.halt_set;

    // result fields
    st_d  = st_q;
    tid_d = tid_q;
    sw_d  = sw_q;
    if (ctrl_i.res_clr) begin
      st_d  = rrts_pkg::RS_NOCHG;
      tid_d = '0;
      sw_d  = 1'b0;
    end
    if (ctrl_i.st_ld) begin
      st_d = ctrl_i.st_val;
    end
    if (ctrl_i.tid_ld) begin
      tid_d = rrts_pkg::TidW'(ptr_q);
    end
    if (ctrl_i.sw_set) begin
      sw_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rrts_pkg::SlotCount; i++) begin
        slot_q[i] <= rrts_pkg::S_FREE;
      end
      cur_q   <= '0;
      cur_v_q <= 1'b0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_q[addr] <= wr_data;
      end
      cur_q   <= cur_d;
      cur_v_q <= cur_v_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      halt_q  <= halt_d;
    end
  end

  // command capture, scan pointer and result fields
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      cmd_q <= cmd_i;
      wid_q <= wid_i;
    end
    ptr_q <= ptr_d;
    it_q  <= it_d;
    st_q  <= st_d;
    tid_q <= tid_d;
    sw_q  <= sw_d;
  end

  assign res_o = '{status: st_q, task_id: tid_q, sw: sw_q, halted: halt_q};

endmodule
